### hdl/pls_pkg.sv
// ----------------------------------------------------------------------------
// pls_pkg
// Shared types and codes for the positional list store: operation and status
// codes, transfer payloads and the command broadcast to the storage cells.
// ----------------------------------------------------------------------------
package pls_pkg;

  localparam int POS_W  = 6;   // position field and cell index width
  localparam int DATA_W = 32;  // data word width
  localparam int LEN_W  = 6;   // length field width

  typedef enum logic [2:0] {
    FN_INS_FRONT = 3'd0,
    FN_INS_BACK  = 3'd1,
    FN_INS_POS   = 3'd2,
    FN_DEL_FRONT = 3'd3,
    FN_DEL_BACK  = 3'd4,
    FN_DEL_POS   = 3'd5,
    FN_READ_FWD  = 3'd6,
    FN_READ_BWD  = 3'd7
  } fn_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } st_t;

  typedef struct packed {
    fn_t                      func;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } pls_in_t;

  typedef struct packed {
    st_t                      status;
    logic signed [DATA_W-1:0] read_value;
    logic [LEN_W-1:0]         length;
    logic                     last;
  } pls_out_t;

  // what every cell does at the next edge
  typedef enum logic [2:0] {
    CK_HOLD  = 3'd0,
    CK_INS   = 3'd1,  // load word at idx, shift cells above idx up
    CK_DEL   = 3'd2,  // cells at idx and above take the right neighbor
    CK_ROT_L = 3'd3,  // whole chain moves toward cell 0
    CK_ROT_R = 3'd4   // whole chain moves away from cell 0
  } cell_kind_t;

  typedef struct packed {
    cell_kind_t               kind;
    logic [POS_W-1:0]         idx;
    logic signed [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

### hdl/pls_cell.sv
// ----------------------------------------------------------------------------
// pls_cell
// One storage cell of the list chain: holds one entry and, on command, loads
// the insert word or takes the word of its left or right neighbor.
// ----------------------------------------------------------------------------
module pls_cell
  import pls_pkg::*;
#(
  parameter int INDEX = 0
) (
  input  logic                     clk,
  input  cell_cmd_t                cmd,
  input  logic signed [DATA_W-1:0] left_value,
  input  logic signed [DATA_W-1:0] right_value,
  output logic signed [DATA_W-1:0] value
);

  localparam logic [POS_W-1:0] MY_IDX = POS_W'(INDEX);

  logic signed [DATA_W-1:0] value_r;
  logic signed [DATA_W-1:0] value_nxt;

  always_comb begin
    value_nxt = value_r;
    unique case (cmd.kind)
      CK_INS: begin
        if (MY_IDX == cmd.idx) begin
          value_nxt = cmd.value;
        end else if (MY_IDX > cmd.idx) begin
          value_nxt = left_value;
        end
      end
      CK_DEL: begin
        if (MY_IDX >= cmd.idx) begin
          value_nxt = right_value;
        end
      end
      CK_ROT_L: value_nxt = right_value;
      CK_ROT_R: value_nxt = left_value;
      default:  value_nxt = value_r;
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value = value_r;

endmodule

### hdl/positional_list_store_top.sv
// ----------------------------------------------------------------------------
// positional_list_store_top
// Ordered store of up to DEPTH signed words with insert and delete at front,
// back or position, and full read-out in either direction.
// ----------------------------------------------------------------------------
// An operation is taken when start is high and busy is low. Insert and delete
// do not raise busy and may follow one another in consecutive cycles; their
// single result appears on out_data with out_valid high in the cycle after the
// transfer. A read-out of a non-empty list holds busy, whatever the length,
// while the chain of cells makes one full rotation so that the entries return
// to their places, and one result per entry streams out at one per cycle,
// last marked on the final one. A read-out of an empty list does not raise
// busy and gives a single result like an insert. The receiver cannot stall: every
// result is shown for exactly one cycle and must be taken then. The length
// field is the entry count modulo 64.
// ----------------------------------------------------------------------------
module positional_list_store_top
  import pls_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  pls_in_t  in_data,
  output logic     out_valid,
  output pls_out_t out_data
);

  localparam int CW   = $clog2(DEPTH + 1);  // entry count width
  localparam int CNTW = $clog2(DEPTH);      // read-out step counter width
  localparam int PW   = ((CW > POS_W) ? CW : POS_W) + 1;  // width for position compares

  // cell chain
  cell_cmd_t                cmd;
  logic signed [DATA_W-1:0] cell_q [DEPTH];

  // control state
  logic [CW-1:0]   fill_r,  fill_nxt;
  logic            busy_r,  busy_nxt;
  logic            bwd_r,   bwd_nxt;
  logic [CNTW-1:0] cnt_r,   cnt_nxt;
  logic            ovld_r,  ovld_nxt;
  pls_out_t        odata_r, odata_nxt;

  logic            accept;
  logic            full;
  logic            empty;
  logic [PW-1:0]   pos_w;
  logic [PW-1:0]   fill_w;
  logic            step_emit;
  logic            step_last;
  logic            step_end;

  assign accept = start && !busy_r;
  assign full   = (fill_r == CW'(DEPTH));
  assign empty  = (fill_r == '0);
  assign pos_w  = PW'(in_data.position);
  assign fill_w = PW'(fill_r);

  // read-out step: forward emits cell 0 for the first fill_r steps,
  // backward emits the top cell for the last fill_r steps
  always_comb begin
    if (bwd_r) begin
      step_emit = (CW'(cnt_r) >= (CW'(DEPTH) - fill_r));
      step_last = (cnt_r == CNTW'(DEPTH - 1));
    end else begin
      step_emit = (CW'(cnt_r) < fill_r);
      step_last = ((CW'(cnt_r) + CW'(1)) == fill_r);
    end
    step_end = (cnt_r == CNTW'(DEPTH - 1));
  end

  always_comb begin
    fill_nxt  = fill_r;
    busy_nxt  = busy_r;
    bwd_nxt   = bwd_r;
    cnt_nxt   = cnt_r;
    ovld_nxt  = 1'b0;
    odata_nxt = odata_r;
    cmd.kind  = CK_HOLD;
    cmd.idx   = '0;
    cmd.value = in_data.value;

    if (busy_r) begin
      // rotation step of a read-out
      cmd.kind = bwd_r ? CK_ROT_R : CK_ROT_L;
      cnt_nxt  = cnt_r + CNTW'(1);
      if (step_end) begin
        busy_nxt = 1'b0;
        cnt_nxt  = '0;
      end
      if (step_emit) begin
        ovld_nxt             = 1'b1;
        odata_nxt.status     = ST_OK;
        odata_nxt.read_value = bwd_r ? cell_q[DEPTH-1] : cell_q[0];
        odata_nxt.length     = LEN_W'(fill_r);
        odata_nxt.last       = step_last;
      end
    end else if (accept) begin
      ovld_nxt             = 1'b1;
      odata_nxt.status     = ST_OK;
      odata_nxt.read_value = '0;
      odata_nxt.last       = 1'b1;
      unique case (in_data.func) inside
        FN_INS_FRONT, FN_INS_BACK: begin
          if (full) begin
            odata_nxt.status = ST_FULL;
          end else begin
            cmd.kind = CK_INS;
            cmd.idx  = (in_data.func == FN_INS_FRONT) ? '0 : POS_W'(fill_r);
            fill_nxt = fill_r + CW'(1);
          end
        end
        FN_INS_POS: begin
          // position check comes before the full check
          if (pos_w == '0 || pos_w > (fill_w + PW'(1))) begin
            odata_nxt.status = ST_BADPOS;
          end else if (full) begin
            odata_nxt.status = ST_FULL;
          end else begin
            cmd.kind = CK_INS;
            cmd.idx  = in_data.position - POS_W'(1);
            fill_nxt = fill_r + CW'(1);
          end
        end
        FN_DEL_FRONT, FN_DEL_BACK: begin
          if (empty) begin
            odata_nxt.status = ST_EMPTY;
          end else begin
            cmd.kind = CK_DEL;
            cmd.idx  = (in_data.func == FN_DEL_FRONT) ? '0 : POS_W'(fill_r - CW'(1));
            fill_nxt = fill_r - CW'(1);
          end
        end
        FN_DEL_POS: begin
          // also covers the empty list
          if (pos_w == '0 || pos_w > fill_w) begin
            odata_nxt.status = ST_BADPOS;
          end else begin
            cmd.kind = CK_DEL;
            cmd.idx  = in_data.position - POS_W'(1);
            fill_nxt = fill_r - CW'(1);
          end
        end
        FN_READ_FWD, FN_READ_BWD: begin
          if (empty) begin
            odata_nxt.status = ST_EMPTY;
          end else begin
            // results come from the rotation steps
            ovld_nxt = 1'b0;
            busy_nxt = 1'b1;
            bwd_nxt  = (in_data.func == FN_READ_BWD);
            cnt_nxt  = '0;
          end
        end
        default: odata_nxt.status = ST_OK;
      endcase
      odata_nxt.length = LEN_W'(fill_nxt);
    end
  end

  // chain of cells, cell 0 holds the front; ends wrap for rotation
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    pls_cell #(
      .INDEX(i)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .left_value (cell_q[(i + DEPTH - 1) % DEPTH]),
      .right_value(cell_q[(i + 1) % DEPTH]),
      .value      (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      busy_r <= 1'b0;
      bwd_r  <= 1'b0;
      cnt_r  <= '0;
      ovld_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      busy_r <= busy_nxt;
      bwd_r  <= bwd_nxt;
      cnt_r  <= cnt_nxt;
      ovld_r <= ovld_nxt;
    end
    odata_r <= odata_nxt;
  end

  assign busy      = busy_r;
  assign out_valid = ovld_r;
  assign out_data  = odata_r;

`ifndef SYNTHESIS
  // entry count never passes capacity
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(DEPTH))
    else $error("entry count above capacity");

  // a read-out never changes the entry count
  a_fill_hold: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |=> $stable(fill_r))
    else $error("entry count changed during read-out");

  // a read-out only runs over a non-empty list
  a_busy_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> fill_r != '0)
    else $error("read-out over an empty list");

  // full status only when the store is at capacity
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (ovld_r && odata_r.status == ST_FULL) |-> fill_r == CW'(DEPTH))
    else $error("full status below capacity");

  // empty status only when nothing is held
  a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
    (ovld_r && odata_r.status == ST_EMPTY) |-> fill_r == '0)
    else $error("empty status with entries held");
`endif

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for positional_list_store_top: a directed table covers
// empty, full and bad-position cases and the value extremes, then biased
// random operations run under several sender idling phases. Every result
// transfer is compared field by field against an in-bench list predictor.
// ----------------------------------------------------------------------------
module testbench
  import pls_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH        = 32;
  localparam int RESET_CYCLES = 12;
  localparam int LIMIT_CYCLES = 200000;  // far above the slowest correct run
  localparam int DRAIN_CYCLES = DEPTH + 8; // one full rotation plus margin
  localparam int MAX_REPORTS  = 10;
  localparam int PHASE_ITEMS  = 106;

  // one line of the directed table; pinned rows carry a result typed in
  typedef struct {
    pls_in_t  op;
    int       count;
    bit       pinned;
    pls_out_t result;
  } stim_row_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  pls_in_t  in_data = '0;
  logic     out_valid;
  pls_out_t out_data;

  // pinned result travels with the command, driven on the same edge
  bit       pin_q = 1'b0;
  pls_out_t pin_res = '0;

  // predictor state: the list itself, front at index 0
  logic signed [DATA_W-1:0] list_words[$];
  // results still owed by the block, oldest first
  pls_out_t results_due[$];

  int fail_count = 0;
  int cycle_count = 0;

  positional_list_store_top #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always #10 clk = ~clk;

  // watchdog on total run length
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, results_due.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic pls_out_t mk_res(st_t s, logic signed [DATA_W-1:0] v,
                                      int unsigned len, bit lst);
    pls_out_t r;
    r.status     = s;
    r.read_value = v;
    r.length     = len[LEN_W-1:0];
    r.last       = lst;
    return r;
  endfunction

  function automatic stim_row_t mk_row(fn_t f, int unsigned p, logic [DATA_W-1:0] v,
                                      int n, bit pin, st_t s, int unsigned len);
    stim_row_t row;
    row.op.func     = f;
    row.op.position = p[POS_W-1:0];
    row.op.value    = v;
    row.count       = n;
    row.pinned      = pin;
    row.result      = mk_res(s, '0, len, 1'b1);
    return row;
  endfunction

  // list update and expected results for one accepted command
  function automatic void list_apply(pls_in_t op, bit pinned, pls_out_t pinned_res);
    st_t         st;
    int unsigned n;
    int unsigned p;
    bit          fwd;
    st  = ST_OK;
    n   = list_words.size();
    p   = op.position;
    fwd = (op.func == FN_READ_FWD);
    case (op.func) inside
      FN_INS_FRONT, FN_INS_BACK, FN_INS_POS: begin
        // position check ranks above the full check
        if (op.func == FN_INS_POS && (p < 1 || p > n + 1)) st = ST_BADPOS;
        else if (n >= DEPTH) st = ST_FULL;
        else if (op.func == FN_INS_FRONT) list_words.insert(0, op.value);
        else if (op.func == FN_INS_BACK) list_words.insert(n, op.value);
        else list_words.insert(p - 1, op.value);
      end
      FN_DEL_FRONT, FN_DEL_BACK: begin
        if (n == 0) st = ST_EMPTY;
        else list_words.delete(op.func == FN_DEL_FRONT ? 0 : n - 1);
      end
      FN_DEL_POS: begin
        // covers the empty list as well
        if (p < 1 || p > n) st = ST_BADPOS;
        else list_words.delete(p - 1);
      end
      default: begin
        if (n == 0) st = ST_EMPTY;
        else begin
          for (int i = 0; i < n; i++)
            results_due.push_back(mk_res(ST_OK, list_words[fwd ? i : n - 1 - i],
                                         n, i == n - 1));
          return;
        end
      end
    endcase
    results_due.push_back(pinned ? pinned_res
                                 : mk_res(st, '0, list_words.size(), 1'b1));
  endfunction

  function automatic void note_failure(string what, pls_out_t e, pls_out_t g);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%s: expected status %0d value %0d length %0d last %0d, %s",
               what, e.status, e.read_value, e.length, e.last,
               $sformatf("got status %0d value %0d length %0d last %0d",
                         g.status, g.read_value, g.length, g.last));
  endfunction

  // result check first, then the command taken on this edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (results_due.size() == 0) begin
          note_failure("unexpected result", '0, out_data);
        end else begin
          if (out_data.status !== results_due[0].status ||
              out_data.read_value !== results_due[0].read_value ||
              out_data.length !== results_due[0].length ||
              out_data.last !== results_due[0].last)
            note_failure("mismatch", results_due[0], out_data);
          void'(results_due.pop_front());
        end
      end
      if (start && busy === 1'b0) list_apply(in_data, pin_q, pin_res);
    end
  end

  // one command transfer, with a random number of idle cycles ahead of it
  task automatic send_op(pls_in_t op, bit pinned, pls_out_t res, int idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start   <= 1'b1;
    in_data <= op;
    pin_q   <= pinned;
    pin_res <= res;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // random command; growing runs lean to inserts so the list reaches full
  function automatic pls_in_t random_op(bit growing);
    pls_in_t     op;
    int unsigned r;
    int unsigned p;
    op.value = $urandom;
    r = $urandom_range(99);
    if (r < 40) p = $urandom_range(1, 4);
    else if (r < 85) p = $urandom_range(1, DEPTH + 1);
    else p = $urandom_range(0, 63);
    op.position = p[POS_W-1:0];
    r = $urandom_range(99);
    if (r < 8) op.func = r[0] ? FN_READ_FWD : FN_READ_BWD;
    else if (r < (growing ? 64 : 40)) op.func = fn_t'(FN_INS_FRONT + $urandom_range(2));
    else op.func = fn_t'(FN_DEL_FRONT + $urandom_range(2));
    return op;
  endfunction

  initial begin
    stim_row_t rows[$];
    pls_in_t   op;
    bit        growing;
    int        run_left;
    int        idle_pct[4];

    // empty list corner cases
    rows.push_back(mk_row(FN_READ_FWD,  0, 32'h0, 1, 1, ST_EMPTY,  0));
    rows.push_back(mk_row(FN_DEL_FRONT, 0, 32'h0, 1, 1, ST_EMPTY,  0));
    rows.push_back(mk_row(FN_DEL_BACK,  0, 32'h0, 1, 1, ST_EMPTY,  0));
    rows.push_back(mk_row(FN_DEL_POS,   1, 32'h0, 1, 1, ST_BADPOS, 0));
    rows.push_back(mk_row(FN_INS_POS,   0, 32'h0, 1, 1, ST_BADPOS, 0));
    rows.push_back(mk_row(FN_INS_POS,   2, 32'h0, 1, 1, ST_BADPOS, 0));
    // value extremes, insert at middle and at length plus one
    rows.push_back(mk_row(FN_INS_FRONT, 0, 32'h8000_0000, 1, 1, ST_OK, 1));
    rows.push_back(mk_row(FN_INS_BACK,  0, 32'h7fff_ffff, 1, 1, ST_OK, 2));
    rows.push_back(mk_row(FN_INS_POS,   2, 32'hffff_ffff, 1, 1, ST_OK, 3));
    rows.push_back(mk_row(FN_INS_POS,   4, 32'h0000_0000, 1, 1, ST_OK, 4));
    rows.push_back(mk_row(FN_READ_FWD,  0, 32'h0, 1, 0, ST_OK, 0));
    rows.push_back(mk_row(FN_READ_BWD,  0, 32'h0, 1, 0, ST_OK, 0));
    // deletes, one past the end rejected
    rows.push_back(mk_row(FN_DEL_POS,   5, 32'h0, 1, 1, ST_BADPOS, 4));
    rows.push_back(mk_row(FN_DEL_POS,   2, 32'h0, 1, 1, ST_OK, 3));
    rows.push_back(mk_row(FN_DEL_FRONT, 0, 32'h0, 1, 1, ST_OK, 2));
    rows.push_back(mk_row(FN_DEL_BACK,  0, 32'h0, 1, 1, ST_OK, 1));
    // fill to capacity with random words, then the full cases
    rows.push_back(mk_row(FN_INS_BACK,  0, 32'h0, DEPTH - 1, 0, ST_OK, 0));
    rows.push_back(mk_row(FN_INS_FRONT, 0, 32'h1234_5678, 1, 1, ST_FULL, DEPTH));
    rows.push_back(mk_row(FN_INS_POS, DEPTH + 1, 32'h0, 1, 1, ST_FULL, DEPTH));
    rows.push_back(mk_row(FN_INS_POS, DEPTH + 2, 32'h0, 1, 1, ST_BADPOS, DEPTH));
    rows.push_back(mk_row(FN_INS_POS,   0, 32'h0, 1, 1, ST_BADPOS, DEPTH));
    rows.push_back(mk_row(FN_READ_FWD,  0, 32'h0, 1, 0, ST_OK, 0));
    rows.push_back(mk_row(FN_READ_BWD,  0, 32'h0, 1, 0, ST_OK, 0));
    rows.push_back(mk_row(FN_DEL_POS, DEPTH, 32'h0, 1, 1, ST_OK, DEPTH - 1));
    rows.push_back(mk_row(FN_DEL_POS,  63, 32'h0, 1, 1, ST_BADPOS, DEPTH - 1));
    rows.push_back(mk_row(FN_DEL_POS,   1, 32'h0, 1, 1, ST_OK, DEPTH - 2));

    // single reset pulse at the start of the run
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, back to back
    foreach (rows[i]) begin
      for (int c = 0; c < rows[i].count; c++) begin
        op = rows[i].op;
        if (rows[i].count > 1) op.value = $urandom;
        send_op(op, rows[i].pinned, rows[i].result, 0);
      end
    end

    // random part: no idling, sender idle 57 in 100, receiver phase (it cannot
    // stall, so the sender runs free), sender idle 27 in 100
    idle_pct = '{0, 57, 0, 27};
    growing  = 1'b1;
    run_left = $urandom_range(30, 90);
    for (int ph = 0; ph < 4; ph++) begin
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (run_left == 0) begin
          growing  = !growing;
          run_left = $urandom_range(30, 90);
        end
        run_left--;
        send_op(random_op(growing), 1'b0, '0, idle_pct[ph]);
      end
    end
    start <= 1'b0;

    // drain outstanding results, then allow for trailing activity
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
